### rtl/core/cffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cffsa_pkg;

    localparam int SLOTS     = 131072;
    localparam int SLOT_W    = 17;
    localparam int COUNT_W   = 18;
    localparam int LEAF_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int WORDS     = SLOTS / LEAF_BITS;
    localparam int WORD_W    = SLOT_W - BIT_W;
    localparam int SUMS      = WORDS / LEAF_BITS;
    localparam int SUM_W     = WORD_W - BIT_W;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_L1,
        ST_REL_S,
        ST_S1,
        ST_S2,
        ST_L2,
        ST_TAKE,
        ST_CLR_S,
        ST_OUT
    } t_state;

    // Leaf word after reinitialization: bit set where the slot lies below the count
    function automatic logic [LEAF_BITS-1:0] leaf_fill(input logic [WORD_W-1:0] w,
                                                      input logic [COUNT_W-1:0] cnt);
        logic [LEAF_BITS-1:0] f;
        f = '0;
        for (int b = 0; b < LEAF_BITS; b++) begin
            f[b] = ({1'b0, w, BIT_W'(b)} < cnt);
        end
        return f;
    endfunction

    // Summary word: bit set where the leaf word holds at least one free slot
    function automatic logic [LEAF_BITS-1:0] sum_fill(input logic [SUM_W-1:0] j,
                                                     input logic [COUNT_W-1:0] cnt);
        logic [LEAF_BITS-1:0] f;
        f = '0;
        for (int b = 0; b < LEAF_BITS; b++) begin
            f[b] = ({1'b0, j, BIT_W'(b), {BIT_W{1'b0}}} < cnt);
        end
        return f;
    endfunction

    // Root bits: one per summary word
    function automatic logic [SUMS-1:0] top_fill(input logic [COUNT_W-1:0] cnt);
        logic [SUMS-1:0] f;
        f = '0;
        for (int j = 0; j < SUMS; j++) begin
            f[j] = ({1'b0, SUM_W'(j), {(2 * BIT_W){1'b0}}} < cnt);
        end
        return f;
    endfunction

    function automatic logic [BIT_W-1:0] lowest64(input logic [LEAF_BITS-1:0] x);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int b = LEAF_BITS - 1; b >= 0; b--) begin
            if (x[b]) r = BIT_W'(b);
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] lowest_top(input logic [SUMS-1:0] x);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int b = SUMS - 1; b >= 0; b--) begin
            if (x[b]) r = SUM_W'(b);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/cffsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cffsa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/circular_first_free_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular first-free slot allocator.
// Input channel (i_valid/o_ready) carries requests: i_mode 0 claims the first free
// slot at or after i_position (wrapping to slot 0), i_mode 1 frees i_position.
// Output channel (o_valid/i_ready) returns o_slot/o_found once per claim; a
// release returns nothing. Config channel (i_cfg_valid/o_cfg_ready) writes the
// slot count and rebuilds the map: slots below the count are free.
// State lives in a 2048 x 64 leaf RAM, a 32 x 64 summary RAM and 32 root flops.
// A claim runs through a chain of RAM reads (at most leaf, summary, summary,
// leaf) plus the write-back of the leaf word and, if it empties, the summary
// word. A release writes the leaf word, then the summary word. One request is in flight.
// After reset, and after each config write, a sweep over the 2048 leaf words rebuilds the
// map (one leaf word per cycle); no request and no config write is taken until
// it ends. The result sits in an output register: if the receiver stalls,
// the next request is still taken and worked up to its write-back, then holds
// until the waiting result leaves.
module circular_first_free_slot_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_mode,
    input  wire logic [cffsa_pkg::SLOT_W-1:0]  i_position,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [cffsa_pkg::SLOT_W-1:0]  o_slot,
    output logic                               o_found,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cffsa_pkg::COUNT_W-1:0] i_cfg_slot_count
);
    import cffsa_pkg::*;

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [WORD_W-1:0]     r_idx, n_idx;
    logic                  r_mode, n_mode;
    logic [SLOT_W-1:0]     r_pos, n_pos;
    logic [WORD_W-1:0]     r_w, n_w;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [LEAF_BITS-1:0]  r_word, n_word;
    logic                  r_found, n_found;
    logic [SUMS-1:0]       r_top, n_top;
    logic                  r_o_valid, n_o_valid;
    logic [SLOT_W-1:0]     r_o_slot, n_o_slot;
    logic                  r_o_found, n_o_found;

    logic                  lf_we, lf_re;
    logic [WORD_W-1:0]     lf_waddr, lf_raddr;
    logic [LEAF_BITS-1:0]  lf_wdata, lf_rdata;
    logic                  sm_we, sm_re;
    logic [SUM_W-1:0]      sm_waddr, sm_raddr;
    logic [LEAF_BITS-1:0]  sm_wdata, sm_rdata;

    logic [SLOT_W-1:0]     w_pos;
    logic [LEAF_BITS-1:0]  w_mask, w_new;
    logic [SUMS-1:0]       w_tmask;
    logic [SUM_W-1:0]      w_j;
    logic [SUM_W-1:0]      w_psum;
    logic [BIT_W-1:0]      w_pwbit;

    cffsa_ram #(.DEPTH(WORDS), .WIDTH(LEAF_BITS)) u_leaf (
        .i_clk  (i_clk),
        .i_we   (lf_we),
        .i_waddr(lf_waddr),
        .i_wdata(lf_wdata),
        .i_re   (lf_re),
        .i_raddr(lf_raddr),
        .o_rdata(lf_rdata)
    );

    cffsa_ram #(.DEPTH(SUMS), .WIDTH(LEAF_BITS)) u_sum (
        .i_clk  (i_clk),
        .i_we   (sm_we),
        .i_waddr(sm_waddr),
        .i_wdata(sm_wdata),
        .i_re   (sm_re),
        .i_raddr(sm_raddr),
        .o_rdata(sm_rdata)
    );

    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_slot      = r_o_slot;
    assign o_found     = r_o_found;

    // Clamp a claim start beyond the map to slot 0
    assign w_pos = (!i_mode && ({1'b0, i_position} >= COUNT_W'(SLOTS))) ? '0 : i_position;

    // Split the held position into summary word and leaf word within it
    assign w_psum  = r_pos[SLOT_W-1:SLOT_W-SUM_W];
    assign w_pwbit = r_pos[SLOT_W-SUM_W-1:BIT_W];

    // Hold state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_count   <= COUNT_W'(SLOTS);
            r_idx     <= '0;
            r_top     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_top     <= n_top;
            r_o_valid <= n_o_valid;
        end
    end

    // Hold request payload and results
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_pos     <= n_pos;
        r_w       <= n_w;
        r_bit     <= n_bit;
        r_word    <= n_word;
        r_found   <= n_found;
        r_o_slot  <= n_o_slot;
        r_o_found <= n_o_found;
    end

    // Sequence the search and the write-back
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_w       = r_w;
        n_bit     = r_bit;
        n_word    = r_word;
        n_found   = r_found;
        n_top     = r_top;
        n_o_valid = r_o_valid;
        n_o_slot  = r_o_slot;
        n_o_found = r_o_found;
        lf_we     = 1'b0;
        lf_waddr  = r_w;
        lf_wdata  = '0;
        lf_re     = 1'b0;
        lf_raddr  = r_w;
        sm_we     = 1'b0;
        sm_waddr  = r_w[WORD_W-1:BIT_W];
        sm_wdata  = '0;
        sm_re     = 1'b0;
        sm_raddr  = r_w[WORD_W-1:BIT_W];
        w_mask    = '0;
        w_new     = '0;
        w_tmask   = '0;
        w_j       = '0;

        // Drop a result the receiver takes
        if (r_o_valid && i_ready) n_o_valid = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                lf_we    = 1'b1;
                lf_waddr = r_idx;
                lf_wdata = leaf_fill(r_idx, r_count);
                if (r_idx < WORD_W'(SUMS)) begin
                    sm_we    = 1'b1;
                    sm_waddr = r_idx[SUM_W-1:0];
                    sm_wdata = sum_fill(r_idx[SUM_W-1:0], r_count);
                end
                n_top = top_fill(r_count);
                if (r_idx == WORD_W'(WORDS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_count = i_cfg_slot_count;
                    n_idx   = '0;
                    n_state = ST_INIT;
                end else if (i_valid) begin
                    n_mode   = i_mode;
                    n_pos    = w_pos;
                    lf_re    = 1'b1;
                    lf_raddr = w_pos[SLOT_W-1:BIT_W];
                    n_state  = ST_L1;
                end
            end
            ST_L1: begin
                n_w = r_pos[SLOT_W-1:BIT_W];
                if (r_mode) begin
                    // Release: set the slot bit and its summary bit
                    lf_we    = 1'b1;
                    lf_waddr = r_pos[SLOT_W-1:BIT_W];
                    lf_wdata = lf_rdata | (LEAF_BITS'(1) << r_pos[BIT_W-1:0]);
                    sm_re    = 1'b1;
                    sm_raddr = w_psum;
                    n_state  = ST_REL_S;
                end else begin
                    w_mask = lf_rdata & ~((LEAF_BITS'(1) << r_pos[BIT_W-1:0]) - 1'b1);
                    if (w_mask != '0) begin
                        n_bit   = lowest64(w_mask);
                        n_word  = lf_rdata;
                        n_state = ST_TAKE;
                    end else begin
                        sm_re    = 1'b1;
                        sm_raddr = w_psum;
                        n_state  = ST_S1;
                    end
                end
            end
            ST_REL_S: begin
                sm_we    = 1'b1;
                sm_waddr = w_psum;
                sm_wdata = sm_rdata | (LEAF_BITS'(1) << w_pwbit);
                n_top[w_psum] = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_S1: begin
                // Look for a later leaf word in this summary word, then a later summary word, else wrap to the first
                w_mask = sm_rdata & ~((LEAF_BITS'(2) << w_pwbit) - 1'b1);
                if (w_mask != '0) begin
                    n_w      = {w_psum, lowest64(w_mask)};
                    lf_re    = 1'b1;
                    lf_raddr = {w_psum, lowest64(w_mask)};
                    n_state  = ST_L2;
                end else begin
                    w_tmask = r_top & ~((SUMS'(2) << w_psum) - 1'b1);
                    if (w_tmask != '0) begin
                        w_j = lowest_top(w_tmask);
                    end else begin
                        w_j = lowest_top(r_top);
                    end
                    if (r_top == '0) begin
                        n_found = 1'b0;
                        n_state = ST_OUT;
                    end else begin
                        sm_re    = 1'b1;
                        sm_raddr = w_j;
                        n_w      = {w_j, {BIT_W{1'b0}}};
                        n_state  = ST_S2;
                    end
                end
            end
            ST_S2: begin
                n_w      = {r_w[WORD_W-1:BIT_W], lowest64(sm_rdata)};
                lf_re    = 1'b1;
                lf_raddr = {r_w[WORD_W-1:BIT_W], lowest64(sm_rdata)};
                n_state  = ST_L2;
            end
            ST_L2: begin
                n_bit   = lowest64(lf_rdata);
                n_word  = lf_rdata;
                n_state = ST_TAKE;
            end
            ST_TAKE: begin
                // Clear the slot bit; walk up if the word empties
                w_new    = r_word & ~(LEAF_BITS'(1) << r_bit);
                lf_we    = 1'b1;
                lf_waddr = r_w;
                lf_wdata = w_new;
                n_found  = 1'b1;
                if (w_new == '0) begin
                    sm_re   = 1'b1;
                    n_state = ST_CLR_S;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_CLR_S: begin
                w_new    = sm_rdata & ~(LEAF_BITS'(1) << r_w[BIT_W-1:0]);
                sm_we    = 1'b1;
                sm_wdata = w_new;
                if (w_new == '0) n_top[r_w[WORD_W-1:BIT_W]] = 1'b0;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_found;
                    n_o_slot  = r_found ? {r_w, r_bit} : '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cffsa_pkg::*;

    localparam int MAX_CYCLES = 3_000_000;

    typedef struct {
        logic             mode;
        logic [SLOT_W-1:0] pos;
        logic             chk;   // typed-in expectation present
        logic [SLOT_W-1:0] slot;
        logic             found;
    } t_row;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              found;
    } t_grant;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_mode;
    logic [SLOT_W-1:0]   i_position;
    logic                o_valid;
    logic                i_ready;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_found;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_slot_count;

    circular_first_free_slot_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_slot           (o_slot),
        .o_found          (o_found),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_slot_count (i_cfg_slot_count)
    );

    // Model state: one bit per slot, 1 = free
    bit     slot_free [SLOTS];
    t_grant grants_due[$];
    int     mismatches;
    int     cycle_cnt;
    bit     stall_hold;

    initial i_clk = 1'b0;

    always #10 i_clk = ~i_clk;

    // Rebuild the occupancy map for a new slot count
    function automatic void refill_map(input logic [COUNT_W-1:0] cnt);
        for (int s = 0; s < SLOTS; s++) slot_free[s] = (s < cnt);
    endfunction

    // Apply one request to the map and queue the grant it yields
    function automatic void apply_request(input logic mode, input logic [SLOT_W-1:0] pos);
        t_grant g;
        int     s;
        if (mode) begin
            slot_free[pos] = 1'b1;
            return;
        end
        g.slot  = '0;
        g.found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            s = (int'(pos) + i) % SLOTS;
            if (slot_free[s]) begin
                slot_free[s] = 1'b0;
                g.slot  = SLOT_W'(s);
                g.found = 1'b1;
                break;
            end
        end
        grants_due.push_back(g);
    endfunction

    function automatic void flag_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
    endfunction

    // Receiver: stall on its own pattern, or hold off for a long stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_hold) begin
            i_ready <= 1'b0;
        end else begin
            case (cycle_cnt[9:8])
                2'd0:    i_ready <= 1'b1;
                2'd1:    i_ready <= ($urandom_range(0, 3) != 0);
                default: i_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Check each accepted grant against the oldest one due
    always @(posedge i_clk) begin
        t_grant g;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (grants_due.size() == 0) begin
                flag_mismatch("unexpected grant, slot", -1, int'(o_slot));
            end else begin
                g = grants_due.pop_front();
                if (o_found !== g.found) flag_mismatch("found", int'(g.found), int'(o_found));
                if (o_slot !== g.slot) flag_mismatch("slot", int'(g.slot), int'(o_slot));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one request and hold it until taken, with a burst gap first
    task automatic send_request(input logic mode, input logic [SLOT_W-1:0] pos, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_position <= pos;
        do @(posedge i_clk); while (!(o_ready && i_valid));
        apply_request(mode, pos);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] cnt);
        i_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_slot_count <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        refill_map(cnt);
    endtask

    // Mostly claims, positions mostly in a window from slot 0, with some releases
    task automatic random_phase(input int n, input int span);
        int burst;
        logic [SLOT_W-1:0] p;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 6) p = SLOT_W'($urandom_range(0, span));
            else p = SLOT_W'($urandom);
            if (burst == 0) burst = $urandom_range(1, 12);
            burst--;
            send_request(($urandom_range(0, 2) == 0), p, (burst == 0) ? $urandom_range(1, 15) : 0);
        end
    endtask

    // Send a row whose grant is typed in, then check the model agrees
    task automatic send_directed(input t_row r);
        t_grant last_g;
        send_request(r.mode, r.pos, $urandom_range(0, 3));
        last_g = grants_due[grants_due.size() - 1];
        if (last_g.slot !== r.slot || last_g.found !== r.found)
            flag_mismatch("typed-in grant vs model", int'(r.slot), int'(last_g.slot));
    endtask

    t_row directed[$];

    function automatic t_row mk(input logic m, input int p, input logic c = 0,
                                input int s = 0, input logic f = 0);
        t_row r;
        r.mode = m; r.pos = SLOT_W'(p); r.chk = c; r.slot = SLOT_W'(s); r.found = f;
        return r;
    endfunction

    initial begin
        mismatches       = 0;
        cycle_cnt        = 0;
        stall_hold       = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_mode           = 1'b0;
        i_position       = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_slot_count = '0;
        refill_map(COUNT_W'(SLOTS));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, after reset every slot is free
        directed.push_back(mk(0, 0, 1, 0, 1));
        directed.push_back(mk(0, 0, 1, 1, 1));
        directed.push_back(mk(0, SLOTS - 1, 1, SLOTS - 1, 1));
        directed.push_back(mk(0, SLOTS - 1, 1, 2, 1));       // wrap to start
        directed.push_back(mk(1, 1));
        directed.push_back(mk(0, 0, 1, 1, 1));
        directed.push_back(mk(1, 5));                         // release of a free slot
        directed.push_back(mk(0, 5, 1, 5, 1));
        directed.push_back(mk(0, 63, 1, 63, 1));
        directed.push_back(mk(0, 64, 1, 64, 1));
        directed.push_back(mk(0, 4095, 1, 4095, 1));
        directed.push_back(mk(0, 4096, 1, 4096, 1));
        directed.push_back(mk(0, 'h15555));
        directed.push_back(mk(0, 'h0AAAA));
        directed.push_back(mk(1, SLOTS - 1));
        directed.push_back(mk(0, 'h1FFC0));
        foreach (directed[i]) begin
            if (directed[i].chk) begin
                send_directed(directed[i]);
            end else begin
                send_request(directed[i].mode, directed[i].pos, $urandom_range(0, 3));
            end
        end

        // Tiny map: fill it, run out, release, regain
        write_count(COUNT_W'(3));
        send_request(0, 2, 0);
        send_request(0, 2, 0);
        send_request(0, 2, 0);
        send_request(0, 0, 1);                                // map exhausted
        send_request(0, SLOTS - 1, 0);
        send_request(1, 1, 0);
        send_request(0, 2, 0);

        // Zero slots free, every claim fails until releases
        write_count(COUNT_W'(0));
        send_request(0, 7, 0);
        send_request(1, SLOTS - 1, 0);
        send_request(0, 0, 0);
        send_request(0, 0, 0);

        // Count beyond slots, with a long receiver stall while requests keep coming
        write_count({COUNT_W{1'b1}});
        fork
            random_phase(60, 300);
            begin
                stall_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                stall_hold = 1'b0;
            end
        join

        // Small pools so that exhaustion and wrap are frequent
        write_count(COUNT_W'(40));
        random_phase(500, 63);
        write_count(COUNT_W'(1));
        random_phase(150, 3);
        write_count(COUNT_W'($urandom_range(100, SLOTS - 1)));
        random_phase(500, 200);
        write_count(COUNT_W'(SLOTS));
        random_phase(600, 150);

        // Drain, then allow a release to settle
        i_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && grants_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
